@@ rtl/oaht_pkg.sv @@
`timescale 1ns / 1ps

package oaht_pkg;

   // Table geometry and field widths
   localparam int TABLE_SIZE  = 32;
   localparam int SLOT_BITS   = $clog2(TABLE_SIZE);
   localparam int COUNT_BITS  = SLOT_BITS + 1;
   localparam int KEY_BITS    = 31;
   localparam int RECORD_BITS = 16;
   localparam int FUNC_BITS   = 2;
   localparam int STAT_BITS   = 2;
   localparam int MARK_BITS   = 2;

   // Decimal digit extraction: n / 10 == (n * 0xCCCCCCCD) >> 35 for any 32-bit n
   localparam int          DIGIT_STEPS = 10;
   localparam int          DCNT_BITS   = 4;
   localparam int          SUM_BITS    = 7;
   localparam int          QUOT_BITS   = KEY_BITS - 3;
   localparam int          RECIP_SHIFT = 35;
   localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;

   // Golden ratio in Q0.32
   localparam logic [31:0] GOLD_Q32 = 32'd2654435769;

   // Operation codes
   localparam logic [FUNC_BITS-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_SEARCH = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd2;

   // Status codes
   localparam logic [STAT_BITS-1:0] STAT_DONE = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_MISS = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_FULL = 2'd2;
   localparam logic [STAT_BITS-1:0] STAT_BAD  = 2'd3;

   // Slot marks
   localparam logic [MARK_BITS-1:0] MARK_FREE = 2'd0;
   localparam logic [MARK_BITS-1:0] MARK_USED = 2'd1;
   localparam logic [MARK_BITS-1:0] MARK_GONE = 2'd2;

   typedef struct packed {
      logic [FUNC_BITS-1:0]   func;
      logic [KEY_BITS-1:0]    key;
      logic [RECORD_BITS-1:0] record_handle;
   } req_type;

   typedef struct packed {
      logic [STAT_BITS-1:0]   status;
      logic [SLOT_BITS-1:0]   slot_index;
      logic [RECORD_BITS-1:0] found_record;
   } rsp_type;

endpackage

@@ rtl/open_addressing_hash_table.sv @@
`timescale 1ns / 1ps
// Hashing: key load, ten digit steps, two multiply stages and a handoff; then one slot probe
//   per cycle, with the result registered after the last probe check. An unused operation
//   code gets its result in the cycle after start.
// Throughput: one beat at a time; busy stays high until the result is produced.
// Reset: synchronous, clears all slot marks to free at once; keys and records are not cleared.
// The receiver cannot stall: rsp_strobe is high for exactly one cycle per beat.
module open_addressing_hash_table import oaht_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_HASH  = 2'd1;
   localparam logic [1:0] S_PROBE = 2'd2;

   logic [1:0]             state_ff, state_in;
   req_type                req_ff, req_in;
   logic [SLOT_BITS-1:0]   idx_ff, idx_in;
   logic [COUNT_BITS-1:0]  n_ff, n_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   rd_last_ff, rd_last_in;
   logic [SLOT_BITS-1:0]   rd_idx_ff, rd_idx_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [MARK_BITS-1:0]   slot_mark [TABLE_SIZE];
   logic [KEY_BITS-1:0]    slot_key [TABLE_SIZE];
   logic [RECORD_BITS-1:0] slot_record [TABLE_SIZE];
   logic [MARK_BITS-1:0]   rd_mark_ff;
   logic [KEY_BITS-1:0]    rd_key_ff;
   logic [RECORD_BITS-1:0] rd_rec_ff;

   logic                   accept;
   logic                   func_ok;
   logic                   hash_go;
   logic                   hash_done;
   logic [SLOT_BITS-1:0]   hash_home;
   logic                   is_insert;
   logic                   hit_ins;
   logic                   hit_fnd;
   logic                   finish;
   logic                   check_done;
   logic                   issue;
   logic                   write_slot;
   logic                   mark_gone;

   assign accept  = start && (state_ff == S_IDLE);
   assign func_ok = (req_data.func == FUNC_INSERT) || (req_data.func == FUNC_SEARCH) ||
                    (req_data.func == FUNC_REMOVE);
   assign hash_go = accept && func_ok;

   oaht_hash u_hash (
      .clock (clock),
      .reset (reset),
      .go    (hash_go),
      .key   (req_data.key),
      .done  (hash_done),
      .home  (hash_home)
   );

   // Probe check on the registered slot read
   assign is_insert  = (req_ff.func == FUNC_INSERT);
   assign hit_ins    = (rd_mark_ff != MARK_USED);
   assign hit_fnd    = (rd_mark_ff == MARK_USED) && (rd_key_ff == req_ff.key);
   assign finish     = is_insert ? (hit_ins || rd_last_ff)
                                 : (hit_fnd || (rd_mark_ff == MARK_FREE) || rd_last_ff);
   assign check_done = (state_ff == S_PROBE) && rd_vld_ff && finish;
   assign issue      = (state_ff == S_PROBE) && !check_done &&
                       (n_ff != COUNT_BITS'(TABLE_SIZE));
   assign write_slot = check_done && is_insert && hit_ins;
   assign mark_gone  = check_done && (req_ff.func == FUNC_REMOVE) && hit_fnd;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      rd_vld_in     = 1'b0;
      rd_last_in    = rd_last_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (func_ok) begin
                  state_in = S_HASH;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '{status: STAT_MISS, slot_index: '0, found_record: '0};
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               idx_in   = hash_home;
               n_in     = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (issue) begin
               rd_vld_in  = 1'b1;
               rd_idx_in  = idx_ff;
               rd_last_in = (n_ff == COUNT_BITS'(TABLE_SIZE - 1));
               idx_in     = (idx_ff == SLOT_BITS'(TABLE_SIZE - 1)) ? '0 : idx_ff + 1'b1;
               n_in       = n_ff + 1'b1;
            end
            if (check_done) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
               if (is_insert) begin
                  if (hit_ins) begin
                     rsp_data_in = '{status: STAT_DONE, slot_index: rd_idx_ff, found_record: '0};
                  end else begin
                     rsp_data_in = '{status: STAT_FULL, slot_index: '0, found_record: '0};
                  end
               end else if (hit_fnd) begin
                  rsp_data_in.status       = STAT_DONE;
                  rsp_data_in.slot_index   = rd_idx_ff;
                  rsp_data_in.found_record = (req_ff.func == FUNC_SEARCH) ? rd_rec_ff : '0;
               end else begin
                  rsp_data_in = '{status: STAT_MISS, slot_index: '0, found_record: '0};
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      rd_last_ff  <= rd_last_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Slot marks: flops, cleared to free on reset, registered read
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) begin
            slot_mark[i] <= MARK_FREE;
         end
      end else if (write_slot) begin
         slot_mark[rd_idx_ff] <= MARK_USED;
      end else if (mark_gone) begin
         slot_mark[rd_idx_ff] <= MARK_GONE;
      end
   end

   always_ff @(posedge clock) begin
      rd_mark_ff <= slot_mark[idx_ff];
   end

   // Key and record stores: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (write_slot) begin
         slot_key[rd_idx_ff]    <= req_ff.key;
         slot_record[rd_idx_ff] <= req_ff.record_handle;
      end
      rd_key_ff <= slot_key[idx_ff];
      rd_rec_ff <= slot_record[idx_ff];
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

@@ rtl/oaht_hash.sv @@
`timescale 1ns / 1ps

// Home slot unit: one decimal digit per cycle, then two multiply stages.
module oaht_hash import oaht_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [KEY_BITS-1:0]  key,
   output logic                 done,
   output logic [SLOT_BITS-1:0] home
);

   localparam logic [1:0] H_IDLE  = 2'd0;
   localparam logic [1:0] H_DIGIT = 2'd1;
   localparam logic [1:0] H_FRAC  = 2'd2;
   localparam logic [1:0] H_SCALE = 2'd3;

   localparam int SCALE_BITS = 32 + SLOT_BITS + 1;

   logic [1:0]            state_ff, state_in;
   logic [KEY_BITS-1:0]   k_ff, k_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [DCNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [31:0]           frac_ff, frac_in;
   logic                  done_ff, done_in;
   logic [SLOT_BITS-1:0]  home_ff, home_in;

   logic [KEY_BITS+31:0]  recip_prod;
   logic [QUOT_BITS-1:0]  quot;
   logic [KEY_BITS-1:0]   ten_quot;
   logic [KEY_BITS-1:0]   rem_full;
   logic [3:0]            digit;
   logic [SLOT_BITS-1:0]  sum_mod;
   logic [31:0]           frac_full;
   logic [SCALE_BITS-1:0] scale_prod;

   // Divide by ten through the reciprocal, remainder by shift-add
   assign recip_prod = {{32{1'b0}}, k_ff} * {{KEY_BITS{1'b0}}, RECIP_10};
   assign quot       = recip_prod[RECIP_SHIFT +: QUOT_BITS];
   assign ten_quot   = {quot, 3'b000} + KEY_BITS'({quot, 1'b0});
   assign rem_full   = k_ff - ten_quot;
   assign digit      = rem_full[3:0];

   // Fractional part of s * A, then scale by the table size
   assign sum_mod    = SLOT_BITS'(sum_ff % TABLE_SIZE);
   assign frac_full  = {{(32-SLOT_BITS){1'b0}}, sum_mod} * GOLD_Q32;
   assign scale_prod = {{(SLOT_BITS+1){1'b0}}, frac_ff} * SCALE_BITS'(TABLE_SIZE);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      frac_in  = frac_ff;
      done_in  = 1'b0;
      home_in  = home_ff;
      unique case (state_ff)
         H_IDLE: begin
            if (go) begin
               k_in     = key;
               sum_in   = '0;
               cnt_in   = '0;
               state_in = H_DIGIT;
            end
         end
         H_DIGIT: begin
            k_in   = KEY_BITS'(quot);
            sum_in = sum_ff + SUM_BITS'(digit);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DCNT_BITS'(DIGIT_STEPS - 1)) begin
               state_in = H_FRAC;
            end
         end
         H_FRAC: begin
            frac_in  = frac_full;
            state_in = H_SCALE;
         end
         H_SCALE: begin
            home_in  = scale_prod[32 +: SLOT_BITS];
            done_in  = 1'b1;
            state_in = H_IDLE;
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      sum_ff  <= sum_in;
      cnt_ff  <= cnt_in;
      frac_ff <= frac_in;
      home_ff <= home_in;
   end

   assign done = done_ff;
   assign home = home_ff;

endmodule

@@ rtl/oaht_checker.sv @@
`timescale 1ns / 1ps

module oaht_checker import oaht_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // A result only appears once the block has gone idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   // An accepted beat either starts work or answers at once
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted beat neither started nor answered");

   // Status is always a defined code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.status != STAT_BAD))
      else $error("undefined status code");

   // Failed operations carry no slot and no record
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != STAT_DONE)) |->
         ((rsp_data.slot_index == '0) && (rsp_data.found_record == '0)))
      else $error("failed operation returned slot or record");

   // An unused operation answers in the next cycle with a miss
   a_bad_func: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.func != FUNC_INSERT) && (req_data.func != FUNC_SEARCH) &&
       (req_data.func != FUNC_REMOVE)) |=> (rsp_strobe && (rsp_data.status == STAT_MISS)))
      else $error("unused operation not answered with a miss");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import oaht_pkg::*;

   // Operation code the block does not define; it must answer with a miss
   localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

   localparam int TOTAL_BEATS  = 1970;
   localparam int QUIET_FROM   = 900;
   localparam int QUIET_TO     = 1300;
   localparam int IDLE_PCT     = 22;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 64;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_data   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Pending requests and expected responses
   req_type req_q[$];
   rsp_type expected_rsp_q[$];

   // Shadow copy of the table
   logic [MARK_BITS-1:0]   mark_shadow[TABLE_SIZE];
   logic [KEY_BITS-1:0]    key_shadow[TABLE_SIZE];
   logic [RECORD_BITS-1:0] record_shadow[TABLE_SIZE];

   int sent_cnt     = 0;
   int error_cnt    = 0;
   int quiet_cycles = 0;
   int n_insert     = 0;
   int n_full       = 0;
   int n_search     = 0;
   int n_search_hit = 0;
   int n_remove     = 0;
   int n_remove_hit = 0;
   int n_unused     = 0;

   open_addressing_hash_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Home slot: digit sum mod size, golden-ratio multiply in Q0.32, top bits scaled
   function automatic int home_slot(logic [KEY_BITS-1:0] key);
      logic [31:0] rest;
      logic [31:0] digit_sum;
      logic [31:0] frac;
      logic [63:0] scaled;
      rest      = 32'(key);
      digit_sum = '0;
      for (int i = 0; i < 10; i++) begin
         digit_sum += rest % 10;
         rest      /= 10;
      end
      digit_sum = digit_sum % TABLE_SIZE;
      frac      = 32'(64'(digit_sum) * 64'(GOLD_Q32));
      scaled    = 64'(frac) * 64'(TABLE_SIZE);
      return int'(scaled >> 32);
   endfunction

   // Apply one operation to the shadow table and return the response it gives
   function automatic rsp_type table_op(req_type r);
      rsp_type o;
      int      idx;
      o        = '0;
      o.status = STAT_MISS;
      idx      = home_slot(r.key);
      case (r.func)
         FUNC_INSERT: begin
            n_insert++;
            o.status = STAT_FULL;
            for (int n = 0; n < TABLE_SIZE; n++) begin
               if (mark_shadow[idx] != MARK_USED) begin
                  mark_shadow[idx]   = MARK_USED;
                  key_shadow[idx]    = r.key;
                  record_shadow[idx] = r.record_handle;
                  o.status           = STAT_DONE;
                  o.slot_index       = SLOT_BITS'(idx);
                  break;
               end
               idx = (idx + 1) % TABLE_SIZE;
            end
            if (o.status == STAT_FULL) n_full++;
         end
         FUNC_SEARCH, FUNC_REMOVE: begin
            if (r.func == FUNC_SEARCH) n_search++;
            else n_remove++;
            // walk the chain; a never-used slot ends it, tombstones are skipped
            for (int n = 0; n < TABLE_SIZE; n++) begin
               if (mark_shadow[idx] == MARK_FREE) break;
               if (mark_shadow[idx] == MARK_USED && key_shadow[idx] == r.key) begin
                  o.status     = STAT_DONE;
                  o.slot_index = SLOT_BITS'(idx);
                  if (r.func == FUNC_SEARCH) begin
                     o.found_record = record_shadow[idx];
                     n_search_hit++;
                  end else begin
                     mark_shadow[idx] = MARK_GONE;
                     n_remove_hit++;
                  end
                  break;
               end
               idx = (idx + 1) % TABLE_SIZE;
            end
         end
         default: begin
            n_unused++;
         end
      endcase
      return o;
   endfunction

   // Driver: present the head of the queue, predict on each accepted beat
   always @(posedge clock) begin
      logic fire;
      logic rest;
      fire = start && !busy;
      rest = (sent_cnt < QUIET_FROM || sent_cnt >= QUIET_TO) &&
             ($urandom_range(99) < IDLE_PCT);
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (fire) begin
            expected_rsp_q.push_back(table_op(req_data));
            void'(req_q.pop_front());
            sent_cnt <= sent_cnt + 1;
         end
         // hold the beat while it waits; pick a new one once it went through
         if (fire || !start) begin
            if (req_q.size() > 0 && !rest) begin
               start    <= 1'b1;
               req_data <= req_q[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobe beat is checked against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            error_cnt++;
            $display("%0t: unexpected response status %0d slot %0d record %h",
                     $time, rsp_data.status, rsp_data.slot_index, rsp_data.found_record);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.status !== want.status) begin
               error_cnt++;
               $display("%0t: status mismatch, expected %0d actual %0d",
                        $time, want.status, rsp_data.status);
            end
            if (rsp_data.slot_index !== want.slot_index) begin
               error_cnt++;
               $display("%0t: slot_index mismatch, expected %0d actual %0d",
                        $time, want.slot_index, rsp_data.slot_index);
            end
            if (rsp_data.found_record !== want.found_record) begin
               error_cnt++;
               $display("%0t: found_record mismatch, expected %h actual %h",
                        $time, want.found_record, rsp_data.found_record);
            end
         end
      end
   end

   // Watchdog: cycles without any beat moving on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   task automatic add_req(logic [FUNC_BITS-1:0] func, logic [KEY_BITS-1:0] key,
                          logic [RECORD_BITS-1:0] rec);
      req_type r;
      r.func          = func;
      r.key           = key;
      r.record_handle = rec;
      req_q.push_back(r);
   endtask

   // Stimulus, reset and end of run
   initial begin
      logic [KEY_BITS-1:0]    key_pool[$];
      logic [KEY_BITS-1:0]    key;
      logic [FUNC_BITS-1:0]   func;
      logic [RECORD_BITS-1:0] rec;
      int                     planned;
      int                     mode;
      int                     seg_len;
      int                     pick;
      int                     ins_pct;
      int                     rem_pct;
      bit                     fresh;

      // empty table: search stops at a free slot, remove of a missing key
      add_req(FUNC_SEARCH, '0, '1);
      add_req(FUNC_REMOVE, 31'd123, '0);
      // field extremes; key zero lands on slot zero
      add_req(FUNC_INSERT, '0, '1);
      add_req(FUNC_INSERT, '1, '0);
      add_req(FUNC_SEARCH, '0, '0);
      add_req(FUNC_SEARCH, '1, '1);
      // duplicate insert takes the next slot
      add_req(FUNC_INSERT, '0, 16'h1234);
      // keys sharing one digit sum probe along the same chain
      add_req(FUNC_INSERT, 31'd9, 16'h0009);
      add_req(FUNC_INSERT, 31'd90, 16'h0090);
      add_req(FUNC_INSERT, 31'd18, 16'h0018);
      add_req(FUNC_INSERT, 31'd900, 16'h0900);
      // tombstone in the middle of the chain is skipped by search
      add_req(FUNC_REMOVE, 31'd90, '0);
      add_req(FUNC_SEARCH, 31'd18, '0);
      add_req(FUNC_SEARCH, 31'd90, '0);
      add_req(FUNC_SEARCH, 31'd900, '0);
      // insert reuses the tombstone
      add_req(FUNC_INSERT, 31'd81, 16'h8181);
      // undefined operation code
      add_req(FUNC_UNUSED, '1, '1);
      // remove both copies of a duplicate, then miss
      add_req(FUNC_REMOVE, '0, '0);
      add_req(FUNC_SEARCH, '0, '0);
      add_req(FUNC_REMOVE, '0, '0);
      add_req(FUNC_REMOVE, '0, '0);
      add_req(FUNC_SEARCH, 31'd81, '0);
      planned = req_q.size();
      key_pool = '{31'd0, 31'd9, 31'd18, 31'd81, 31'd900, 31'h7FFF_FFFF};

      // random segments: balanced, insert burst (fills the table), remove heavy
      while (planned < TOTAL_BEATS) begin
         mode    = $urandom_range(2);
         seg_len = $urandom_range(40, 140);
         ins_pct = (mode == 1) ? 80 : (mode == 2) ? 10 : 35;
         rem_pct = (mode == 1) ? 5 : (mode == 2) ? 45 : 25;
         for (int j = 0; j < seg_len && planned < TOTAL_BEATS; j++) begin
            pick = $urandom_range(99);
            if (pick < 4) func = FUNC_UNUSED;
            else if (pick < 4 + ins_pct) func = FUNC_INSERT;
            else if (pick < 4 + ins_pct + rem_pct) func = FUNC_REMOVE;
            else func = FUNC_SEARCH;
            fresh = (func == FUNC_INSERT) ? ($urandom_range(99) < 30)
                                          : ($urandom_range(99) < 15);
            if (fresh) begin
               case ($urandom_range(2))
                  0: key = KEY_BITS'($urandom);
                  1: key = KEY_BITS'($urandom_range(999));
                  default: key = KEY_BITS'($urandom_range(32'h7FFF_FFFF, 1000000000));
               endcase
               if (func == FUNC_INSERT) begin
                  key_pool.push_back(key);
                  if (key_pool.size() > 48) void'(key_pool.pop_front());
               end
            end else begin
               key = key_pool[$urandom_range(key_pool.size() - 1)];
            end
            rec = RECORD_BITS'($urandom);
            add_req(func, key, rec);
            planned++;
         end
      end

      foreach (mark_shadow[i]) mark_shadow[i] = MARK_FREE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (req_q.size() != 0 || expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d operations: %0d inserts (%0d on a full table), %0d searches (%0d hits),",
               sent_cnt, n_insert, n_full, n_search, n_search_hit);
      $display("  %0d removes (%0d hits), %0d undefined op codes; %0d mismatches",
               n_remove, n_remove_hit, n_unused, error_cnt);
      if (error_cnt == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
